// ----- rtl/rmmc_pkg.sv -----
// Package for the desk riser mode controller: payload structs, phase codes,
// mode and register index constants. Used by riser_motor_mode_controller_core.
`timescale 1ns / 1ps

package rmmc_pkg;

    localparam int SECONDS_WIDTH_DEF = 12;
    localparam int PERIOD_WIDTH      = 12;
    localparam int CFG_INDEX_WIDTH   = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIT_SECONDS   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STAND_SECONDS = 2'd1;

    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] MODE_TIMER  = 2'd2;

    typedef enum logic [3:0] {
        PH_SELECT     = 4'd0,
        PH_MANUAL     = 4'd1,
        PH_AUTO       = 4'd2,
        PH_SIT_WAIT   = 4'd3,
        PH_SIT_ACK    = 4'd4,
        PH_DRIVE_ONE  = 4'd5,
        PH_STAND_WAIT = 4'd6,
        PH_STAND_ACK  = 4'd7,
        PH_DRIVE_TWO  = 4'd8
    } phase_t;

    typedef struct packed {
        logic enter_key;
        logic up_key;
        logic down_key;
        logic ack_key;
        logic presence_left;
        logic presence_mid;
        logic presence_right;
        logic limit_one;
        logic limit_two;
        logic second_tick;
    } in_item_t;

    typedef struct packed {
        logic       motor_a;
        logic       motor_b;
        logic       alert_led;
        logic [1:0] chosen_mode;
        logic       running;
    } out_item_t;

endpackage

// ----- rtl/riser_motor_mode_controller_core.sv -----
// Mode selection and motor control for a sit/stand desk riser.
// Depends on rmmc_pkg for payload structs, phase codes and constants.
// An accepted input item's result is registered and shows on m_ the next cycle.
// Throughput: one item per cycle while m_ready is high; the phase and counter
// registers update in the accepting cycle, the result register refilled as taken.
// Reset (aresetn low, synchronous): mode selection, manual choice, counter
// and drives cleared, both periods 0, no result pending.
`timescale 1ns / 1ps

module riser_motor_mode_controller_core #(
    parameter int SECONDS_WIDTH = rmmc_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  rmmc_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output rmmc_pkg::out_item_t                   m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rmmc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [rmmc_pkg::PERIOD_WIDTH-1:0]     cfg_data
);
    import rmmc_pkg::*;

    localparam int CMP_WIDTH = (SECONDS_WIDTH > PERIOD_WIDTH) ? SECONDS_WIDTH : PERIOD_WIDTH;
    localparam logic [SECONDS_WIDTH-1:0] SECONDS_MAX = {SECONDS_WIDTH{1'b1}};

    phase_t                    phase_reg, phase_next;
    logic [1:0]                mode_reg, mode_next;
    logic [SECONDS_WIDTH-1:0]  count_reg, count_next;
    logic                      drive_a_reg, drive_a_next;
    logic                      drive_b_reg, drive_b_next;
    logic                      led_reg, led_next;
    logic [PERIOD_WIDTH-1:0]   sit_reg, stand_reg;
    logic                      m_valid_reg;
    out_item_t                 m_data_reg;

    logic                      accept;
    logic [SECONDS_WIDTH-1:0]  count_inc;
    logic                      sit_done, stand_done;
    logic [1:0]                mode_eff;
    logic                      keys_idle;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Saturating tick count shared by both wait phases, and one period compare for each
    assign count_inc  = (s_data.second_tick && count_reg != SECONDS_MAX)
                        ? count_reg + 1'b1 : count_reg;
    assign sit_done   = CMP_WIDTH'(count_inc) >= CMP_WIDTH'(sit_reg);
    assign stand_done = CMP_WIDTH'(count_inc) >= CMP_WIDTH'(stand_reg);
    assign mode_eff   = (mode_reg == 2'd3) ? MODE_MANUAL : mode_reg;
    assign keys_idle  = !s_data.ack_key && !s_data.enter_key;

    // Next phase and mode choice
    always_comb begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        case (phase_reg)
            PH_MANUAL, PH_AUTO: begin
            end
            PH_SIT_WAIT: begin
                if (sit_done) phase_next = PH_SIT_ACK;
            end
            PH_SIT_ACK: begin
                if (s_data.ack_key) phase_next = PH_DRIVE_ONE;
            end
            PH_DRIVE_ONE: begin
                if (s_data.limit_one) phase_next = PH_STAND_WAIT;
            end
            PH_STAND_WAIT: begin
                if (stand_done) phase_next = PH_STAND_ACK;
            end
            PH_STAND_ACK: begin
                if (s_data.ack_key) phase_next = PH_DRIVE_TWO;
            end
            PH_DRIVE_TWO: begin
                if (s_data.limit_two) phase_next = PH_SIT_WAIT;
            end
            default: begin
                phase_next = PH_SELECT;
                mode_next  = mode_eff;
                if (s_data.enter_key) begin
                    case (mode_eff)
                        MODE_MANUAL: phase_next = PH_MANUAL;
                        MODE_AUTO:   phase_next = PH_AUTO;
                        default:     phase_next = PH_SIT_WAIT;
                    endcase
                end else if (s_data.up_key && !s_data.down_key) begin
                    mode_next = (mode_eff == MODE_TIMER) ? MODE_MANUAL : mode_eff + 2'd1;
                end else if (!s_data.up_key && s_data.down_key) begin
                    mode_next = (mode_eff == MODE_MANUAL) ? MODE_TIMER : mode_eff - 2'd1;
                end
            end
        endcase
    end

    // Drives, LED and seconds counter
    always_comb begin
        drive_a_next = drive_a_reg;
        drive_b_next = drive_b_reg;
        led_next     = led_reg;
        count_next   = count_reg;
        case (phase_reg)
            PH_MANUAL: begin
                if (keys_idle) begin
                    if (s_data.up_key && !s_data.down_key) begin
                        drive_a_next = 1'b0;
                        drive_b_next = !s_data.limit_one;
                    end else if (!s_data.up_key && s_data.down_key) begin
                        drive_a_next = !s_data.limit_two;
                        drive_b_next = 1'b0;
                    end else if (!s_data.up_key && !s_data.down_key) begin
                        drive_a_next = 1'b0;
                        drive_b_next = 1'b0;
                    end
                end
            end
            PH_AUTO: begin
                drive_a_next = s_data.presence_left && s_data.presence_mid &&
                               s_data.presence_right && !s_data.limit_two;
                drive_b_next = !s_data.presence_left && !s_data.presence_mid &&
                               !s_data.presence_right && !s_data.limit_one;
            end
            PH_SIT_WAIT: begin
                count_next = count_inc;
                if (sit_done) led_next = 1'b1;
            end
            PH_STAND_WAIT: begin
                count_next = count_inc;
                if (stand_done) led_next = 1'b1;
            end
            PH_SIT_ACK, PH_STAND_ACK: begin
                if (s_data.ack_key) led_next = 1'b0;
            end
            PH_DRIVE_ONE: begin
                if (s_data.limit_one) begin
                    drive_a_next = 1'b0;
                    drive_b_next = 1'b0;
                    led_next     = 1'b0;
                    count_next   = '0;
                end else begin
                    drive_a_next = 1'b0;
                    drive_b_next = 1'b1;
                end
            end
            PH_DRIVE_TWO: begin
                if (s_data.limit_two) begin
                    drive_a_next = 1'b0;
                    drive_b_next = 1'b0;
                    led_next     = 1'b0;
                    count_next   = '0;
                end else begin
                    drive_a_next = 1'b1;
                    drive_b_next = 1'b0;
                end
            end
            default: begin
                if (s_data.enter_key) begin
                    drive_a_next = 1'b0;
                    drive_b_next = 1'b0;
                    led_next     = 1'b0;
                    count_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SELECT;
            mode_reg    <= MODE_MANUAL;
            count_reg   <= '0;
            drive_a_reg <= 1'b0;
            drive_b_reg <= 1'b0;
            led_reg     <= 1'b0;
            sit_reg     <= '0;
            stand_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SIT_SECONDS:   sit_reg   <= cfg_data;
                    CFG_STAND_SECONDS: stand_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                phase_reg   <= phase_next;
                mode_reg    <= mode_next;
                count_reg   <= count_next;
                drive_a_reg <= drive_a_next;
                drive_b_reg <= drive_b_next;
                led_reg     <= led_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register needs no reset: m_valid_reg qualifies it
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.motor_a     <= drive_a_next;
            m_data_reg.motor_b     <= drive_b_next;
            m_data_reg.alert_led   <= led_next;
            m_data_reg.chosen_mode <= mode_next;
            m_data_reg.running     <= (phase_next != PH_SELECT);
        end
    end

`ifndef SYNTHESIS
    a_drive_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.motor_a && m_data_reg.motor_b))
        else $error("both motor lines driven");

    a_idle_when_selecting: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.running) |->
        (!m_data_reg.motor_a && !m_data_reg.motor_b && !m_data_reg.alert_led))
        else $error("drive or LED active while selecting");

    a_led_only_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.alert_led) |->
        (m_data_reg.running && m_data_reg.chosen_mode == MODE_TIMER))
        else $error("LED lit outside timer mode");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted item produced no result");

    a_mode_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != 2'd3)
        else $error("mode choice out of range");
`endif

endmodule
